FILE: rtl/graph_store_with_depth_first_path_macros.svh
// assertion macros for the graph store block
// no dependencies
`ifndef GRAPH_STORE_WITH_DEPTH_FIRST_PATH_MACROS_SVH
`define GRAPH_STORE_WITH_DEPTH_FIRST_PATH_MACROS_SVH

// implication checked on every edge outside reset
`define GS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define GS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gsdfp_pkg.sv
// package for the graph store block: sizes, operation and status codes
// no dependencies
package gsdfp_pkg;
  localparam int MaxVertices  = 32;
  localparam int MaxNeighbors = 32;
  localparam int SlotW  = $clog2(MaxVertices);
  localparam int NbrW   = $clog2(MaxNeighbors);
  localparam int TotW   = 6;
  localparam int NbrAw  = SlotW + NbrW;

  localparam logic [2:0] OP_ADD_VERTEX = 3'd0;
  localparam logic [2:0] OP_ADD_EDGE   = 3'd1;
  localparam logic [2:0] OP_REM_EDGE   = 3'd2;
  localparam logic [2:0] OP_REM_VERTEX = 3'd3;
  localparam logic [2:0] OP_FIND_PATH  = 3'd4;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_START_MISSING = 3'd1;
  localparam logic [2:0] ST_END_MISSING   = 3'd2;
  localparam logic [2:0] ST_EDGE_ABSENT   = 3'd3;
  localparam logic [2:0] ST_NO_PATH       = 3'd4;
  localparam logic [2:0] ST_FULL          = 3'd5;
  localparam logic [2:0] ST_DUPLICATE     = 3'd6;

  typedef struct packed {
    logic [2:0] status;
    logic       trace_valid;
    logic [7:0] trace_id;
    logic       last;
  } res_t;
endpackage

FILE: rtl/gsdfp_out_buf.sv
// two-entry output buffer for result items
// depends on gsdfp_pkg
module gsdfp_out_buf
  import gsdfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic empty,
  output logic out_tvalid,
  input  logic out_tready,
  output res_t out_data
);
  res_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_data   = mem_r[rp_r];
  assign space      = (cnt_r == 2'd0);
  assign empty      = (cnt_r == 2'd0);

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

FILE: rtl/graph_store_with_depth_first_path.sv
// channel | dir | handshake          | payload
// in_     | in  | tvalid/tready      | tdata: operation, vertex_id, other_id
// out_    | out | tvalid/tready      | tdata: status, trace_id; tuser: trace_valid; tlast
// cfg_    | in  | apb psel/penable   | register 0: directed_mode
// one item at a time, accepted only in idle; remove vertex and search walk the
// neighbor memory, which every walk reads one entry per step
// synchronous active-low reset clears control and marks, not the memories
// each result needs the output buffer empty; the sequencer stalls until it drains
// depends on gsdfp_pkg, gsdfp_out_buf and the macros header
`include "graph_store_with_depth_first_path_macros.svh"
module graph_store_with_depth_first_path
  import gsdfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[2:0], vertex_id[10:3], other_id[18:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[2:0], trace_id[10:3]
  output logic        out_tuser,  // trace_valid
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam logic [4:0] S_IDLE = 5'd0, S_FA = 5'd1, S_FA_CHK = 5'd2,
    S_DISPATCH = 5'd3, S_EMIT = 5'd4, S_RE_RD = 5'd5, S_RE_CHK = 5'd6,
    S_RE_SH = 5'd7, S_RV_RD = 5'd8, S_RV_CHK = 5'd9, S_RV_CP_RD = 5'd10,
    S_RV_CP_WR = 5'd11, S_DF_TOP = 5'd12, S_DF_RD = 5'd13, S_DF_CHK = 5'd14,
    S_DF_TRACE = 5'd15, S_AE2 = 5'd16, S_RE_SH2 = 5'd17;

  // configuration
  logic dir_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'd0, dir_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) dir_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) dir_r <= cfg_pwdata[0];
  end

  // stores
  logic [7:0]       ids_mem   [MaxVertices];
  logic [TotW-1:0]  tot_mem   [MaxVertices];
  logic [SlotW-1:0] nbr_mem   [MaxVertices*MaxNeighbors];
  logic [SlotW+TotW-1:0] stk_mem [MaxVertices];
  logic [MaxVertices-1:0] vis_r;

  logic [4:0]  st_r;
  logic [2:0]  op_r;
  logic [7:0]  aid_r, bid_r;
  logic [TotW-1:0] vt_r;
  logic [TotW-1:0] i_r;          // slot scan / row index
  logic [TotW-1:0] k_r, w_r, n_r;
  logic [SlotW-1:0] a_r, b_r, s_r, t_r;
  logic        af_r, bf_r, hit_r, mir_r;
  logic [TotW-1:0] dep_r;
  logic [2:0]  rst_st_r;
  logic [SlotW-1:0] nbr_q;
  logic [NbrAw-1:0] nbr_ra;
  logic        nbr_we;
  logic [NbrAw-1:0] nbr_wa;
  logic [SlotW-1:0] nbr_wd;
  res_t        push_d;
  logic        push, space, empty;
  res_t        od;

  gsdfp_out_buf u_obuf (
    .clk, .rst_n, .push, .push_data(push_d), .space, .empty,
    .out_tvalid, .out_tready, .out_data(od)
  );
  assign out_tdata = {5'd0, od.trace_id, od.status};
  assign out_tuser = od.trace_valid;
  assign out_tlast = od.last;
  assign in_tready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    nbr_q <= nbr_mem[nbr_ra];
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
  end

  function automatic logic [NbrAw-1:0] na(input logic [SlotW-1:0] s, input logic [TotW-1:0] k);
    return {s, k[NbrW-1:0]};
  endfunction

  logic [SlotW-1:0] si;
  logic [TotW-1:0]  ntot;
  logic [SlotW+TotW-1:0] top;
  assign si  = i_r[SlotW-1:0];
  assign top = stk_mem[dep_r[SlotW-1:0] - 1'b1];

  always_comb begin
    nbr_ra = na(s_r, k_r);
    nbr_we = 1'b0; nbr_wa = na(s_r, w_r); nbr_wd = nbr_q;
    push = 1'b0; push_d = '0;
    ntot = tot_mem[s_r];
    case (st_r)
      // append t to the end of the list of s
      S_AE2:    begin nbr_we = 1'b1; nbr_wa = na(s_r, ntot); nbr_wd = t_r; end
      S_RE_SH:  begin nbr_ra = na(s_r, k_r + 1'b1); end
      S_RE_SH2: begin nbr_we = 1'b1; nbr_wa = na(s_r, k_r - 1'b1); end
      S_RV_RD:  begin nbr_ra = na(si, k_r); end
      S_RV_CHK: begin
        nbr_ra = na(si, k_r);
        nbr_wa = na(si, w_r);
        nbr_wd = (nbr_q > a_r) ? nbr_q - 1'b1 : nbr_q;
        nbr_we = (k_r != 6'd0) && (nbr_q != a_r) && (si != a_r);
      end
      S_RV_CP_RD: begin nbr_ra = na(si + 1'b1, k_r); end
      S_RV_CP_WR: begin nbr_we = 1'b1; nbr_wa = na(si, k_r); end
      S_EMIT: begin push = space; push_d.status = rst_st_r; push_d.last = 1'b1; end
      S_DF_TRACE: begin push = space; push_d.trace_valid = 1'b1; push_d.trace_id = ids_mem[t_r]; end
      S_IDLE, S_FA, S_FA_CHK, S_DISPATCH, S_RE_RD, S_RE_CHK, S_DF_TOP,
      S_DF_RD, S_DF_CHK: begin end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vt_r <= '0; vis_r <= '0;
    end else begin
      case (st_r)
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[2:0]; aid_r <= in_tdata[10:3]; bid_r <= in_tdata[18:11];
          af_r <= 1'b0; bf_r <= 1'b0; i_r <= '0;
          st_r <= (in_tdata[2:0] > OP_FIND_PATH) ? S_IDLE : S_FA;
        end
        S_FA: begin
          if (i_r == vt_r) st_r <= S_DISPATCH;
          else begin
            if (!af_r && ids_mem[si] == aid_r) begin af_r <= 1'b1; a_r <= si; end
            if (!bf_r && ids_mem[si] == bid_r) begin bf_r <= 1'b1; b_r <= si; end
            i_r <= i_r + 1'b1;
          end
        end
        S_DISPATCH: begin
          case (op_r)
            OP_ADD_VERTEX: begin
              st_r <= S_EMIT;
              if (af_r) rst_st_r <= ST_DUPLICATE;
              else if (vt_r == TotW'(MaxVertices)) rst_st_r <= ST_FULL;
              else begin
                ids_mem[vt_r[SlotW-1:0]] <= aid_r; tot_mem[vt_r[SlotW-1:0]] <= '0;
                vt_r <= vt_r + 1'b1; rst_st_r <= ST_OK;
              end
            end
            OP_REM_VERTEX: begin
              if (!af_r) begin rst_st_r <= ST_START_MISSING; st_r <= S_EMIT; end
              else begin rst_st_r <= ST_OK; i_r <= '0; k_r <= '0; w_r <= '0; st_r <= S_RV_RD; end
            end
            default: begin
              if (!af_r) begin rst_st_r <= ST_START_MISSING; st_r <= S_EMIT; end
              else if (!bf_r) begin rst_st_r <= ST_END_MISSING; st_r <= S_EMIT; end
              else if (op_r == OP_ADD_EDGE) begin
                if ({1'b0, tot_mem[a_r]} + ((!dir_r && a_r == b_r) ? 7'd2 : 7'd1)
                    > 7'(MaxNeighbors)) begin
                  rst_st_r <= ST_FULL; st_r <= S_EMIT;
                end else if (!dir_r && a_r != b_r && tot_mem[b_r] >= TotW'(MaxNeighbors)) begin
                  rst_st_r <= ST_FULL; st_r <= S_EMIT;
                end else begin
                  rst_st_r <= ST_OK; s_r <= a_r; t_r <= b_r; st_r <= S_AE2; mir_r <= 1'b0;
                end
              end else if (op_r == OP_REM_EDGE) begin
                s_r <= a_r; t_r <= b_r; mir_r <= 1'b0; k_r <= '0; st_r <= S_RE_RD;
              end else begin
                // fresh marks with only the start set
                vis_r <= {{(MaxVertices-1){1'b0}}, 1'b1} << a_r;
                t_r <= a_r; st_r <= S_DF_TRACE;
                stk_mem[0] <= {6'd0, a_r}; dep_r <= 6'd1; hit_r <= (a_r == b_r);
              end
            end
          endcase
        end
        S_AE2: begin
          // append t to list of s, then mirror once when undirected
          tot_mem[s_r] <= ntot + 1'b1;
          if (!dir_r && !mir_r) begin mir_r <= 1'b1; s_r <= t_r; t_r <= s_r; end
          else st_r <= S_EMIT;
        end
        S_RE_RD: begin
          if (k_r >= ntot) begin
            if (!mir_r) begin hit_r <= 1'b0; rst_st_r <= ST_EDGE_ABSENT; end
            if (!dir_r && !mir_r) begin mir_r <= 1'b1; s_r <= t_r; t_r <= s_r; k_r <= '0; end
            else st_r <= S_EMIT;
          end else st_r <= S_RE_CHK;
        end
        S_RE_CHK: begin
          if (nbr_q == t_r) begin
            if (!mir_r) rst_st_r <= ST_OK;
            tot_mem[s_r] <= ntot - 1'b1; st_r <= S_RE_SH; n_r <= ntot;
          end else begin k_r <= k_r + 1'b1; st_r <= S_RE_RD; end
        end
        S_RE_SH: begin
          if (k_r + 1'b1 >= n_r) begin
            if (!dir_r && !mir_r) begin
              mir_r <= 1'b1; s_r <= t_r; t_r <= s_r; k_r <= '0; st_r <= S_RE_RD;
            end else st_r <= S_EMIT;
          end else begin k_r <= k_r + 1'b1; st_r <= S_RE_SH2; end
        end
        S_RE_SH2: st_r <= S_RE_SH;
        S_RV_RD: begin
          // scan row i, compacting out references to a and renumbering higher slots
          if (i_r == vt_r) begin i_r <= {1'b0, a_r}; k_r <= '0; st_r <= S_RV_CP_RD; end
          else if (si == a_r || tot_mem[si] == 0) begin i_r <= i_r + 1'b1; end
          else begin k_r <= 6'd0; w_r <= '0; st_r <= S_RV_CHK; end
        end
        S_RV_CHK: begin
          // nbr_q holds entry k-1 once k > 0
          if (k_r != 6'd0 && nbr_q != a_r) w_r <= w_r + 1'b1;
          if (k_r == tot_mem[si]) begin
            tot_mem[si] <= w_r + ((nbr_q != a_r) ? 6'd1 : 6'd0);
            i_r <= i_r + 1'b1; st_r <= S_RV_RD;
          end else k_r <= k_r + 1'b1;
        end
        S_RV_CP_RD: begin
          if (i_r + 1'b1 >= vt_r) begin vt_r <= vt_r - 1'b1; st_r <= S_EMIT; end
          else st_r <= S_RV_CP_WR;
        end
        S_RV_CP_WR: begin
          if (k_r == TotW'(MaxNeighbors - 1)) begin
            ids_mem[si] <= ids_mem[si + 1'b1]; tot_mem[si] <= tot_mem[si + 1'b1];
            k_r <= '0; i_r <= i_r + 1'b1;
          end else k_r <= k_r + 1'b1;
          st_r <= S_RV_CP_RD;
        end
        S_DF_TRACE: if (space) begin
          if (hit_r) begin rst_st_r <= ST_OK; st_r <= S_EMIT; end
          else st_r <= S_DF_TOP;
        end
        S_DF_TOP: begin
          if (dep_r == 0) begin rst_st_r <= ST_NO_PATH; st_r <= S_EMIT; end
          else begin
            s_r <= top[SlotW-1:0]; k_r <= top[SlotW+TotW-1:SlotW];
            if (top[SlotW+TotW-1:SlotW] >= tot_mem[top[SlotW-1:0]]) dep_r <= dep_r - 1'b1;
            else begin
              stk_mem[dep_r[SlotW-1:0] - 1'b1] <=
                {top[SlotW+TotW-1:SlotW] + 1'b1, top[SlotW-1:0]};
              st_r <= S_DF_RD;
            end
          end
        end
        S_DF_RD: st_r <= S_DF_CHK;
        S_DF_CHK: begin
          if ({1'b0, nbr_q} >= vt_r || vis_r[nbr_q]) st_r <= S_DF_TOP;
          else begin
            vis_r[nbr_q] <= 1'b1; t_r <= nbr_q; hit_r <= (nbr_q == b_r);
            if (dep_r < TotW'(MaxVertices)) begin
              stk_mem[dep_r[SlotW-1:0]] <= {6'd0, nbr_q}; dep_r <= dep_r + 1'b1;
            end
            st_r <= S_DF_TRACE;
          end
        end
        S_EMIT: if (space) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `GS_ASSERT_IMPL(a_ready_idle, in_tready, st_r == S_IDLE, "ready outside idle")
  `GS_ASSERT_IMPL(a_vt_bound, 1'b1, vt_r <= TotW'(MaxVertices), "vertex total overflow")
  `GS_ASSERT_IMPL(a_empty_quiet, empty, !out_tvalid, "valid from an empty buffer")
  `GS_ASSERT_NEXT(a_emit_done, st_r == S_EMIT && space, st_r == S_IDLE, "status not closing item")
endmodule

FILE: tb/graph_store_with_depth_first_path_checker.sv
// checker for the graph store block: watches the item and config channels,
// predicts every result and compares it. depends on gsdfp_pkg
`timescale 1ns / 100ps
module graph_store_with_depth_first_path_checker
  import gsdfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // operation[2:0], vertex_id[10:3], other_id[18:11]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // status[2:0], trace_id[10:3]
  input  logic        out_tuser,  // trace_valid
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          outstanding
);
  localparam logic [1:0] DIRECTED_MODE_ADDR = 2'd0;

  // shadow graph
  bit         directed;
  logic [7:0] ids [MaxVertices];
  int         vcount;
  int         ntot [MaxVertices];
  int         nbr [MaxVertices][MaxNeighbors];
  bit         seen [MaxVertices];
  int         stk_slot [MaxVertices];
  int         stk_idx [MaxVertices];
  res_t       pending_results [$];

  function automatic void queue_result(logic [2:0] st, logic tv, logic [7:0] tid, logic lst);
    res_t r;
    r.status = st;
    r.trace_valid = tv;
    r.trace_id = tid;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic int locate(logic [7:0] id);
    for (int i = 0; i < vcount; i++)
      if (ids[i] == id) return i;
    return -1;
  endfunction

  // drop the first entry equal to t from slot s, shifting later entries down
  function automatic bit drop_first(int s, int t);
    int n;
    n = ntot[s];
    for (int k = 0; k < n; k++) begin
      if (nbr[s][k] == t) begin
        for (int j = k; j < n - 1; j++) nbr[s][j] = nbr[s][j + 1];
        nbr[s][n - 1] = 0;
        ntot[s] = n - 1;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic logic [2:0] link(int a, int b);
    int need;
    need = (!directed && a == b) ? 2 : 1;
    if (ntot[a] + need > MaxNeighbors) return ST_FULL;
    if (!directed && a != b && ntot[b] >= MaxNeighbors) return ST_FULL;
    nbr[a][ntot[a]] = b;
    ntot[a]++;
    if (!directed) begin
      nbr[b][ntot[b]] = a;
      ntot[b]++;
    end
    return ST_OK;
  endfunction

  // drop references, renumber, then compact the slots
  function automatic void unlink_vertex(int pos);
    int w;
    int v;
    for (int i = 0; i < vcount; i++) begin
      if (i == pos) continue;
      w = 0;
      for (int k = 0; k < ntot[i]; k++) begin
        v = nbr[i][k];
        if (v == pos) continue;
        nbr[i][w] = (v > pos) ? v - 1 : v;
        w++;
      end
      for (int k = w; k < ntot[i]; k++) nbr[i][k] = 0;
      ntot[i] = w;
    end
    for (int i = pos; i + 1 < vcount; i++) begin
      ids[i] = ids[i + 1];
      ntot[i] = ntot[i + 1];
      for (int k = 0; k < MaxNeighbors; k++) nbr[i][k] = nbr[i + 1][k];
    end
    ids[vcount - 1] = '0;
    ntot[vcount - 1] = 0;
    for (int k = 0; k < MaxNeighbors; k++) nbr[vcount - 1][k] = 0;
    vcount--;
  endfunction

  // depth-first walk: one trace per visited vertex, then the status
  function automatic void walk_path(int start, int target);
    int depth;
    int s;
    int k;
    int n;
    for (int i = 0; i < MaxVertices; i++) seen[i] = 0;
    seen[start] = 1;
    queue_result(ST_OK, 1'b1, ids[start], 1'b0);
    if (start == target) begin
      queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
      return;
    end
    depth = 1;
    stk_slot[0] = start;
    stk_idx[0] = 0;
    while (depth > 0) begin
      s = stk_slot[depth - 1];
      k = stk_idx[depth - 1];
      if (k >= ntot[s] || k >= MaxNeighbors) begin
        depth--;
        continue;
      end
      stk_idx[depth - 1] = k + 1;
      n = nbr[s][k];
      if (n >= vcount || seen[n]) continue;
      seen[n] = 1;
      queue_result(ST_OK, 1'b1, ids[n], 1'b0);
      if (n == target) begin
        queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
        return;
      end
      if (depth < MaxVertices) begin
        stk_slot[depth] = n;
        stk_idx[depth] = 0;
        depth++;
      end
    end
    queue_result(ST_NO_PATH, 1'b0, 8'd0, 1'b1);
  endfunction

  function automatic void apply_item(logic [2:0] op, logic [7:0] a_id, logic [7:0] b_id);
    int a;
    int b;
    logic [2:0] st;
    a = locate(a_id);
    b = locate(b_id);
    case (op)
      OP_ADD_VERTEX: begin
        if (a >= 0) st = ST_DUPLICATE;
        else if (vcount >= MaxVertices) st = ST_FULL;
        else begin
          ids[vcount] = a_id;
          ntot[vcount] = 0;
          vcount++;
          st = ST_OK;
        end
        queue_result(st, 1'b0, 8'd0, 1'b1);
      end
      OP_ADD_EDGE, OP_REM_EDGE, OP_FIND_PATH: begin
        if (a < 0) queue_result(ST_START_MISSING, 1'b0, 8'd0, 1'b1);
        else if (b < 0) queue_result(ST_END_MISSING, 1'b0, 8'd0, 1'b1);
        else if (op == OP_ADD_EDGE) queue_result(link(a, b), 1'b0, 8'd0, 1'b1);
        else if (op == OP_REM_EDGE) begin
          // mirror entry goes even when the forward one is absent
          st = drop_first(a, b) ? ST_OK : ST_EDGE_ABSENT;
          if (!directed) void'(drop_first(b, a));
          queue_result(st, 1'b0, 8'd0, 1'b1);
        end else walk_path(a, b);
      end
      OP_REM_VERTEX: begin
        if (a < 0) queue_result(ST_START_MISSING, 1'b0, 8'd0, 1'b1);
        else begin
          unlink_vertex(a);
          queue_result(ST_OK, 1'b0, 8'd0, 1'b1);
        end
      end
      default: ;  // unused codes give no result
    endcase
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      directed = 1'b0;
      vcount = 0;
      fail_count = 0;
      pending_results.delete();
      outstanding = 0;
      for (int i = 0; i < MaxVertices; i++) begin
        ids[i] = '0;
        ntot[i] = 0;
        for (int k = 0; k < MaxNeighbors; k++) nbr[i][k] = 0;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == DIRECTED_MODE_ADDR)
        directed = cfg_pwdata[0];
      if (in_tvalid && in_tready)
        apply_item(in_tdata[2:0], in_tdata[10:3], in_tdata[18:11]);
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.trace_valid = out_tuser;
        got.trace_id = out_tdata[10:3];
        got.last = out_tlast;
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: status %0d trace %0b id %0d last %0b",
                     got.status, got.trace_valid, got.trace_id, got.last);
          fail_count = fail_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status || got.trace_valid != want.trace_valid ||
              got.trace_id != want.trace_id || got.last != want.last) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d %0b %0d %0b, got %0d %0b %0d %0b",
                       want.status, want.trace_valid, want.trace_id, want.last,
                       got.status, got.trace_valid, got.trace_id, got.last);
            fail_count = fail_count + 1;
          end
        end
      end
      outstanding = pending_results.size();
    end
  end
endmodule

FILE: tb/graph_store_with_depth_first_path_tb.sv
// top of the graph store testbench: clock, reset, item and config stimulus
// depends on gsdfp_pkg, the block and graph_store_with_depth_first_path_checker
`timescale 1ns / 100ps
module graph_store_with_depth_first_path_tb;
  import gsdfp_pkg::*;

  localparam logic [1:0] DIRECTED_MODE_ADDR = 2'd0;
  localparam int SETTLE_CYCLES = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TOTAL_ITEMS = 290;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // operation[2:0], vertex_id[10:3], other_id[18:11]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // status[2:0], trace_id[10:3]
  logic        out_tuser;        // trace_valid
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  bit calm = 1'b0;            // no random idling on either side while set
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  logic [7:0] id_pool [16];

  graph_store_with_depth_first_path i_dut (.*);

  graph_store_with_depth_first_path_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 12);
    end
  end

  // offer one item, with an occasional gap in front of it
  task automatic send_item(logic [2:0] op, logic [7:0] a_id, logic [7:0] b_id);
    if (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, b_id, a_id, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // wait until every predicted result has come back
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // register writes only while the block is quiet
  task automatic write_mode(logic mode);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= DIRECTED_MODE_ADDR;
    cfg_pwdata <= {31'b0, mode};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // mostly ids from a small pool so operations hit existing vertices
  function automatic logic [7:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(15)];
    return 8'($urandom_range(255));
  endfunction

  // random mix with occasional structured bursts that fill the tables
  task automatic random_phase(int count);
    int stop;
    int pick;
    logic [7:0] hub;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        // enough adds to run the slot table full
        for (int i = 0; i < 34; i++) send_item(OP_ADD_VERTEX, 8'($urandom_range(255)), 8'd0);
      end else if (pick < 6) begin
        // many edges from one hub to overflow its neighbor list
        hub = id_pool[$urandom_range(15)];
        send_item(OP_ADD_VERTEX, hub, 8'd0);
        for (int i = 0; i < 34; i++) send_item(OP_ADD_EDGE, hub, pick_id());
      end else if (pick < 28) begin
        send_item(OP_ADD_VERTEX, pick_id(), 8'($urandom_range(255)));
      end else if (pick < 55) begin
        send_item(OP_ADD_EDGE, pick_id(), pick_id());
      end else if (pick < 65) begin
        send_item(OP_REM_EDGE, pick_id(), pick_id());
      end else if (pick < 72) begin
        send_item(OP_REM_VERTEX, pick_id(), 8'($urandom_range(255)));
      end else if (pick < 95) begin
        send_item(OP_FIND_PATH, pick_id(), pick_id());
      end else begin
        // unused codes: no result, ignored by the block
        send_item(3'($urandom_range(5, 7)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    id_pool[0] = 8'h00;
    id_pool[1] = 8'hFF;
    id_pool[2] = 8'hA5;
    id_pool[3] = 8'h5A;
    for (int i = 4; i < 16; i++) id_pool[i] = 8'($urandom_range(255));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, undirected mode
    write_mode(1'b0);
    send_item(OP_ADD_VERTEX, 8'h00, 8'h00);
    send_item(OP_ADD_VERTEX, 8'hFF, 8'hFF);
    send_item(OP_ADD_VERTEX, 8'h00, 8'h00);   // duplicate id
    send_item(OP_ADD_EDGE, 8'h00, 8'hFF);
    send_item(OP_ADD_EDGE, 8'hFF, 8'hFF);     // self loop stored twice
    send_item(OP_REM_EDGE, 8'h00, 8'h00);     // edge absent
    send_item(OP_FIND_PATH, 8'h00, 8'hFF);
    send_item(OP_FIND_PATH, 8'h00, 8'h00);    // start equals target
    send_item(OP_FIND_PATH, 8'h12, 8'h00);    // start missing
    send_item(OP_FIND_PATH, 8'h00, 8'h12);    // end missing
    send_item(OP_ADD_EDGE, 8'h12, 8'h00);
    send_item(OP_REM_VERTEX, 8'h12, 8'h00);   // unknown id
    send_item(3'd5, 8'hFF, 8'hFF);
    send_item(3'd6, 8'h00, 8'h00);
    send_item(3'd7, 8'hFF, 8'hFF);
    send_item(OP_REM_EDGE, 8'h00, 8'hFF);
    send_item(OP_FIND_PATH, 8'h00, 8'hFF);    // no path any more
    send_item(OP_REM_VERTEX, 8'h00, 8'h00);
    send_item(OP_REM_EDGE, 8'hFF, 8'hFF);
    send_item(OP_REM_VERTEX, 8'hFF, 8'h00);

    // directed edges
    write_mode(1'b1);
    random_phase(85);

    // mirrored edges, no random idling; long receiver hold and a sender pause
    write_mode(1'b0);
    calm = 1'b1;
    random_phase(40);
    hold_requests++;
    random_phase(20);
    drain();
    random_phase(30);
    calm = 1'b0;

    write_mode(1'b1);
    random_phase(TOTAL_ITEMS - items_sent);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
